// ----- rtl/md4_hash_engine_defines.svh -----
// assertion helpers shared by the md4 engine files
`ifndef MD4_HASH_ENGINE_DEFINES_SVH
`define MD4_HASH_ENGINE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MD4_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MD4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/md4_pkg.sv -----
`default_nettype none

package md4_pkg;

	localparam logic [3:0][31:0] MD4_IV = {
		32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};
	localparam logic [31:0] MD4_K2      = 32'h5A827999;
	localparam logic [31:0] MD4_K3      = 32'h6ED9EBA1;
	localparam logic [7:0]  MD4_PAD     = 8'h80;
	localparam logic [5:0]  MD4_LAST_STEP = 6'd47;
	localparam logic [5:0]  MD4_LAST_BYTE = 6'd63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTES,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_FFWD,
		ST_OUT
	} md4_state_t;

	// which block is being compressed
	typedef enum logic [1:0] {
		PH_DATA,
		PH_PAD,
		PH_FINAL
	} md4_phase_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       ffwd;
		logic       clr;
		logic [5:0] step_idx;
	} md4_rnd_ctrl_t;

	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_pos;
		logic [7:0] wr_byte;
		logic [3:0] rd_idx;
		logic       zero_lo;
		logic       len_sel;
	} md4_buf_ctrl_t;

	// message word used by a step
	function automatic logic [3:0] md4_word_sel(input logic [5:0] i);
		logic [3:0] sel;
		unique case (i[5:4])
			2'd0:    sel = i[3:0];
			2'd1:    sel = {i[1:0], i[3:2]};
			default: sel = {i[0], i[1], i[2], i[3]};
		endcase
		return sel;
	endfunction

	// left rotate amount of a step
	function automatic logic [4:0] md4_rot(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'b0000: s = 5'd3;
			4'b0001: s = 5'd7;
			4'b0010: s = 5'd11;
			4'b0011: s = 5'd19;
			4'b0100: s = 5'd3;
			4'b0101: s = 5'd5;
			4'b0110: s = 5'd9;
			4'b0111: s = 5'd13;
			4'b1000: s = 5'd3;
			4'b1001: s = 5'd9;
			4'b1010: s = 5'd11;
			4'b1011: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/md4_msg_buf.sv -----
`default_nettype none

module md4_msg_buf
	import md4_pkg::*;
(
	input  wire logic          clk,
	input  wire md4_buf_ctrl_t ctrl,
	input  wire logic [63:0]   bit_len,
	output logic [31:0]        rd_word
);

	logic [15:0][31:0] buf_q;

	// byte-wide writes, byte i of the block in word i/4, lane i%4
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			buf_q[ctrl.wr_pos[5:2]][{ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
		end
	end

	// length words and the all-zero extra block are muxed in on read
	always_comb begin
		if (ctrl.len_sel && ctrl.rd_idx == 4'd14) begin
			rd_word = bit_len[31:0];
		end else if (ctrl.len_sel && ctrl.rd_idx == 4'd15) begin
			rd_word = bit_len[63:32];
		end else if (ctrl.zero_lo) begin
			rd_word = '0;
		end else begin
			rd_word = buf_q[ctrl.rd_idx];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/md4_round_unit.sv -----
`default_nettype none

module md4_round_unit
	import md4_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire md4_rnd_ctrl_t ctrl,
	input  wire logic [31:0]   w,
	output logic [3:0][31:0]   cv
);

	logic [3:0][31:0] cv_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f, k, sum;
	logic [63:0] dbl;
	logic [4:0]  s;

	always_comb begin
		unique case (ctrl.step_idx[5:4])
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = '0;
			end
			2'd1: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = MD4_K2;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = MD4_K3;
			end
		endcase
		s   = md4_rot(ctrl.step_idx);
		sum = a_q + f + w + k;
		dbl = {sum, sum} << s;
	end

	// working words rotate a <- d, b <- new, c <- b, d <- c
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
		end else if (ctrl.step) begin
			a_q <= d_q;
			b_q <= dbl[63:32];
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= MD4_IV;
		end else if (ctrl.clr) begin
			cv_q <= MD4_IV;
		end else if (ctrl.ffwd) begin
			cv_q[0] <= cv_q[0] + a_q;
			cv_q[1] <= cv_q[1] + b_q;
			cv_q[2] <= cv_q[2] + c_q;
			cv_q[3] <= cv_q[3] + d_q;
		end
	end

	assign cv = cv_q;

endmodule

`default_nettype wire

// ----- rtl/md4_hash_engine.sv -----
`default_nettype none

// md4 digest engine (rfc 1320). message words come in little endian, first
// byte in bits 7..0, with a valid byte count (values above four count as
// four) and a last flag; an empty message is one last word with zero bytes.
// bytes are packed into the 64-byte block one per cycle, held off while a
// full block is compressed; a word is not taken until the previous one is packed.
// each filled block then runs the 48-step compression through one shared
// step unit, one step per cycle, after a load step and before a
// feed-forward step.
// after the last word the pad sweep writes 0x80 and zeros one byte per cycle
// up to the block end, then one or two more compressions
// run; the length words are muxed in on read rather than written. the four
// digest words A, B, C, D then leave as four output transfers, digest_last on
// D, and the engine drops back to its reset state. msg_ready is high only
// while the engine is idle.
module md4_hash_engine
	import md4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_ready,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  word_bytes,
	input  wire logic        last_word,
	output logic             digest_valid,
	input  wire logic        digest_ready,
	output logic [31:0]      digest_word,
	output logic [1:0]       digest_index,
	output logic             digest_last
);

`include "md4_hash_engine_defines.svh"

	md4_state_t    state_q, state_d;
	md4_phase_t    phase_q;
	md4_rnd_ctrl_t rnd_ctrl;
	md4_buf_ctrl_t buf_ctrl;

	logic [31:0]      word_q;
	logic [2:0]       nb_q;      // clamped byte count of the held word
	logic [2:0]       bi_q;      // next byte of the held word
	logic             last_q;
	logic [5:0]       pos_q;     // byte position in the block
	logic [60:0]      len_q;     // message length in bytes, wraps like the bit count
	logic             pad_first_q;
	logic             pad_hi_q;  // 0x80 landed at byte 56 or later: two pad blocks
	logic [5:0]       step_q;
	logic [1:0]       out_idx_q;
	logic [31:0]      rd_word;
	logic [3:0][31:0] cv;
	logic [7:0]       cur_byte;
	logic             in_xfer, out_xfer, byte_wr, pad_wr;

	assign in_xfer  = msg_valid && msg_ready;
	assign out_xfer = digest_valid && digest_ready;
	assign cur_byte = 8'(word_q >> {bi_q[1:0], 3'b000});
	assign byte_wr  = (state_q == ST_BYTES) && (bi_q != nb_q);
	assign pad_wr   = (state_q == ST_PAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d      = state_q;
		msg_ready    = 1'b0;
		digest_valid = 1'b0;
		rnd_ctrl     = '0;
		rnd_ctrl.step_idx = step_q;
		buf_ctrl     = '0;
		buf_ctrl.wr_pos  = pos_q;
		buf_ctrl.rd_idx  = md4_word_sel(step_q);
		buf_ctrl.len_sel = (phase_q == PH_FINAL);
		buf_ctrl.zero_lo = (phase_q == PH_FINAL) && pad_hi_q;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					state_d = ST_BYTES;
				end
			end
			ST_BYTES: begin
				if (bi_q != nb_q) begin
					buf_ctrl.wr_en   = 1'b1;
					buf_ctrl.wr_byte = cur_byte;
					if (pos_q == MD4_LAST_BYTE) begin
						state_d = ST_LOAD;
					end else if (bi_q + 3'd1 == nb_q) begin
						state_d = last_q ? ST_PAD : ST_IDLE;
					end
				end else begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				buf_ctrl.wr_en   = 1'b1;
				buf_ctrl.wr_byte = pad_first_q ? MD4_PAD : 8'h00;
				if (pos_q == MD4_LAST_BYTE) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				rnd_ctrl.load = 1'b1;
				state_d = ST_COMP;
			end
			ST_COMP: begin
				rnd_ctrl.step = 1'b1;
				if (step_q == MD4_LAST_STEP) begin
					state_d = ST_FFWD;
				end
			end
			ST_FFWD: begin
				rnd_ctrl.ffwd = 1'b1;
				unique case (phase_q)
					PH_DATA:  state_d = ST_BYTES;
					PH_PAD:   state_d = ST_LOAD;
					default:  state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				if (digest_ready && out_idx_q == 2'd3) begin
					rnd_ctrl.clr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// held word, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			word_q <= message_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q        <= '0;
			bi_q        <= '0;
			last_q      <= 1'b0;
			pos_q       <= '0;
			len_q       <= '0;
			pad_first_q <= 1'b0;
			pad_hi_q    <= 1'b0;
			phase_q     <= PH_DATA;
			step_q      <= '0;
			out_idx_q   <= '0;
		end else begin
			if (in_xfer) begin
				nb_q        <= word_bytes[2] ? 3'd4 : word_bytes;
				bi_q        <= '0;
				last_q      <= last_word;
				pad_first_q <= 1'b1;
			end
			if (byte_wr) begin
				bi_q  <= bi_q + 3'd1;
				pos_q <= pos_q + 6'd1;
				len_q <= len_q + 61'd1;
				if (pos_q == MD4_LAST_BYTE) begin
					phase_q <= PH_DATA;
				end
			end
			if (pad_wr) begin
				pos_q       <= pos_q + 6'd1;
				pad_first_q <= 1'b0;
				if (pad_first_q) begin
					pad_hi_q <= (pos_q[5:3] == 3'b111);
				end
				// pad sweep ends; the first pad block may or may not hold the length
				if (pos_q == MD4_LAST_BYTE) begin
					if (pad_first_q) begin
						phase_q <= (pos_q[5:3] == 3'b111) ? PH_PAD : PH_FINAL;
					end else begin
						phase_q <= pad_hi_q ? PH_PAD : PH_FINAL;
					end
				end
			end
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_COMP) begin
				step_q <= step_q + 6'd1;
			end
			if (state_q == ST_FFWD && phase_q == PH_PAD) begin
				phase_q <= PH_FINAL;
			end
			if (out_xfer) begin
				out_idx_q <= out_idx_q + 2'd1;
				if (out_idx_q == 2'd3) begin
					len_q   <= '0;
					phase_q <= PH_DATA;
				end
			end
		end
	end

	md4_msg_buf u_buf (
		.clk     (clk),
		.ctrl    (buf_ctrl),
		.bit_len ({len_q, 3'b000}),
		.rd_word (rd_word)
	);

	md4_round_unit u_rnd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rnd_ctrl),
		.w      (rd_word),
		.cv     (cv)
	);

	// digest words come straight off the chaining registers
	assign digest_word  = cv[out_idx_q];
	assign digest_index = out_idx_q;
	assign digest_last  = (out_idx_q == 2'd3);

	`MD4_ASSERT_NOW(a_ready_not_busy, msg_ready, !digest_valid && state_q == ST_IDLE,
		"input ready while engine busy")
	`MD4_ASSERT_NOW(a_step_range, state_q == ST_COMP, step_q <= MD4_LAST_STEP,
		"compression step out of range")
	`MD4_ASSERT_NEXT(a_comp_ends, state_q == ST_COMP && step_q == MD4_LAST_STEP,
		state_q == ST_FFWD, "compression did not end after step 47")
	`MD4_ASSERT_NEXT(a_clean_restart, out_xfer && digest_last,
		state_q == ST_IDLE && pos_q == 6'd0 && len_q == 61'd0 && out_idx_q == 2'd0,
		"engine not back to reset state after digest")
	`MD4_ASSERT_NOW(a_pad_at_block_end, state_q == ST_LOAD && phase_q != PH_DATA,
		pos_q == 6'd0, "pad block compressed before sweep finished")

endmodule

`default_nettype wire

// ----- sim/md4_digest_checker.sv -----
module md4_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	input  logic        msg_ready,
	input  logic [31:0] message_word,
	input  logic [2:0]  word_bytes,
	input  logic        last_word,
	input  logic        digest_valid,
	input  logic        digest_ready,
	input  logic [31:0] digest_word,
	input  logic [1:0]  digest_index,
	input  logic        digest_last,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [31:0] ROUND2_ADD = 32'h5A827999;
	localparam logic [31:0] ROUND3_ADD = 32'h6ED9EBA1;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [2:0]  MAX_BYTES = 3'd4;
	localparam int          LEN_OFFSET = 56;
	localparam logic [1:0]  INDEX_D = 2'd3;

	// rotate amounts per step within a group of four
	localparam logic [3:0][4:0] ROT_F = {5'd19, 5'd11, 5'd7, 5'd3};
	localparam logic [3:0][4:0] ROT_G = {5'd13, 5'd9, 5'd5, 5'd3};
	localparam logic [3:0][4:0] ROT_H = {5'd15, 5'd11, 5'd9, 5'd3};

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_beat_t;

	digest_beat_t expected_digest_q[$];
	logic [31:0]  chain_state[4];
	logic [7:0]   block_bytes[64];
	logic [5:0]   fill_count;
	logic [63:0]  bit_count;

	function automatic void clear_message_state();
		chain_state[0] = INIT_A;
		chain_state[1] = INIT_B;
		chain_state[2] = INIT_C;
		chain_state[3] = INIT_D;
		foreach (block_bytes[i])
			block_bytes[i] = 8'h00;
		fill_count = '0;
		bit_count = '0;
	endfunction

	function automatic void md4_compress_block();
		logic [31:0] v[4];
		logic [31:0] x, y, z, f, k, w, sum;
		int t, j, widx, s;
		for (int i = 0; i < 4; i++)
			v[i] = chain_state[i];
		for (int step = 0; step < 48; step++) begin
			// the updated register walks a, d, c, b
			t = (4 - (step & 3)) & 3;
			x = v[(t + 1) & 3];
			y = v[(t + 2) & 3];
			z = v[(t + 3) & 3];
			j = step & 15;
			if (step < 16) begin
				f = (x & y) | (~x & z);
				k = '0;
				widx = j;
				s = int'(ROT_F[step & 3]);
			end else if (step < 32) begin
				f = (x & y) | (x & z) | (y & z);
				k = ROUND2_ADD;
				widx = (j & 3) * 4 + (j >> 2);
				s = int'(ROT_G[step & 3]);
			end else begin
				f = x ^ y ^ z;
				k = ROUND3_ADD;
				// bit-reversed word order
				widx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
				s = int'(ROT_H[step & 3]);
			end
			w = {block_bytes[4 * widx + 3], block_bytes[4 * widx + 2],
				block_bytes[4 * widx + 1], block_bytes[4 * widx]};
			sum = v[t] + f + w + k;
			v[t] = (sum << s) | (sum >> (32 - s));
		end
		for (int i = 0; i < 4; i++)
			chain_state[i] = chain_state[i] + v[i];
	endfunction

	function automatic void absorb_message_word(input logic [31:0] data, input logic [2:0] count,
			input logic is_last);
		int nbytes, pos;
		digest_beat_t beat;
		nbytes = int'((count > MAX_BYTES) ? MAX_BYTES : count);
		for (int i = 0; i < nbytes; i++) begin
			block_bytes[fill_count] = data[8 * i +: 8];
			bit_count = bit_count + 64'd8;
			fill_count = fill_count + 6'd1;
			if (fill_count == '0)
				md4_compress_block();
		end
		if (!is_last)
			return;
		pos = int'(fill_count);
		block_bytes[pos] = PAD_BYTE;
		for (int i = pos + 1; i < 64; i++)
			block_bytes[i] = 8'h00;
		// no room left for the length, so it goes into an extra block
		if (pos >= LEN_OFFSET) begin
			md4_compress_block();
			foreach (block_bytes[i])
				block_bytes[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			block_bytes[LEN_OFFSET + i] = bit_count[8 * i +: 8];
		md4_compress_block();
		for (int i = 0; i < 4; i++) begin
			beat.word = chain_state[i];
			beat.index = i[1:0];
			beat.last = (i[1:0] == INDEX_D);
			expected_digest_q.push_back(beat);
		end
		clear_message_state();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t want;
		if (!arst_n) begin
			clear_message_state();
			expected_digest_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (digest_valid && digest_ready) begin
				if (expected_digest_q.size() == 0) begin
					$error("digest transfer with nothing expected: digest_word %08h index %0d",
						digest_word, digest_index);
					fail_count++;
				end else begin
					want = expected_digest_q.pop_front();
					if (digest_word !== want.word) begin
						$error("digest_word: expected %08h, actual %08h", want.word, digest_word);
						fail_count++;
					end
					if (digest_index !== want.index) begin
						$error("digest_index: expected %0d, actual %0d", want.index, digest_index);
						fail_count++;
					end
					if (digest_last !== want.last) begin
						$error("digest_last: expected %0b, actual %0b", want.last, digest_last);
						fail_count++;
					end
				end
			end
			if (msg_valid && msg_ready)
				absorb_message_word(message_word, word_bytes, last_word);
			pending_count = expected_digest_q.size();
		end
	end

endmodule

// ----- sim/tb_md4_hash_engine.sv -----
module tb_md4_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         HALF_PERIOD = 6;
	localparam int         RESET_CYCLES = 6;
	localparam int         RANDOM_WORDS = 140;
	localparam int         CYCLE_LIMIT = 500000;
	// longest tail: pad sweep, two compressions and the digest transfers
	localparam int         SETTLE_CYCLES = 400;
	localparam logic [2:0] EMPTY_WORD = 3'd0;
	localparam logic [2:0] FULL_WORD = 3'd4;
	localparam logic [2:0] OVER_COUNT = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        msg_valid;
	logic        msg_ready;
	logic [31:0] message_word;
	logic [2:0]  word_bytes;
	logic        last_word;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  digest_index;
	logic        digest_last;

	int fail_count;
	int pending_count;
	int send_idle = 0;     // percent of cycles the sender holds off
	int recv_idle = 0;     // percent of cycles the receiver stalls
	int words_sent = 0;
	int messages_sent = 0;

	md4_hash_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.message_word (message_word),
		.word_bytes   (word_bytes),
		.last_word    (last_word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

	// watches both channels, predicts the digests and compares them
	md4_digest_checker digest_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_ready     (msg_ready),
		.message_word  (message_word),
		.word_bytes    (word_bytes),
		.last_word     (last_word),
		.digest_valid  (digest_valid),
		.digest_ready  (digest_ready),
		.digest_word   (digest_word),
		.digest_index  (digest_index),
		.digest_last   (digest_last),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		digest_ready <= ($urandom_range(99) >= recv_idle);
	end

	// hard stop if the engine hangs or a digest never shows up
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d digest words still outstanding",
			CYCLE_LIMIT, pending_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// one message word transfer: optional idle gap, then hold until accepted
	task automatic send_word(input logic [31:0] data, input logic [2:0] count,
			input logic is_last);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			msg_valid <= 1'b0;
		end
		@(negedge clk);
		msg_valid <= 1'b1;
		message_word <= data;
		word_bytes <= count;
		last_word <= is_last;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		words_sent++;
		if (is_last)
			messages_sent++;
	endtask

	// drop valid and hold off until every predicted digest word is out
	task automatic wait_for_digests();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// random message: mostly full words, some around the padding boundary,
	// some with arbitrary byte counts on every word
	task automatic send_random_message();
		int kind, nwords;
		logic [2:0] count;
		kind = $urandom_range(9);
		if (kind <= 5)
			nwords = $urandom_range(1, 18);
		else if (kind == 6)
			nwords = $urandom_range(14, 15);
		else if (kind == 7)
			nwords = 1;
		else
			nwords = $urandom_range(1, 40);
		for (int k = 0; k < nwords - 1; k++) begin
			count = FULL_WORD;
			if (kind >= 8 || $urandom_range(15) == 0)
				count = 3'($urandom_range(7));
			send_word($urandom, count, 1'b0);
		end
		// boundary messages land between 52 and 60 bytes
		count = (kind == 6) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(7));
		send_word($urandom, count, 1'b1);
	endtask

	initial begin
		int random_base, progress;
		bit paused;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		message_word = '0;
		word_bytes = EMPTY_WORD;
		last_word = 1'b0;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle = 32;
		recv_idle = 65;

		// empty message; the word content must be ignored
		send_word(32'hFFFF_FFFF, EMPTY_WORD, 1'b1);
		// "abc"
		send_word(32'h0063_6261, 3'd3, 1'b1);
		send_word(32'hFFFF_FFFF, FULL_WORD, 1'b1);
		// count above four behaves as four
		send_word(32'h0000_0000, OVER_COUNT, 1'b1);
		// short words in the middle pack with no gap
		send_word(32'hA5A5_A5A5, 3'd1, 1'b0);
		send_word(32'h5A5A_5A5A, 3'd2, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
		// exactly one block, padding starts a fresh block
		for (int k = 0; k < 15; k++)
			send_word($urandom, FULL_WORD, 1'b0);
		send_word($urandom, FULL_WORD, 1'b1);

		random_base = words_sent;
		while (words_sent < random_base + RANDOM_WORDS) begin
			progress = words_sent - random_base;
			if (progress < RANDOM_WORDS / 3) begin
				send_idle = 32;
				recv_idle = 65;
			end else if (progress < 2 * RANDOM_WORDS / 3) begin
				// one full drain with the sender quiet before the swap
				if (!paused) begin
					wait_for_digests();
					paused = 1'b1;
				end
				send_idle = 65;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_random_message();
		end

		wait_for_digests();
		// catch any stray digest transfer after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d messages in %0d word transfers, %0d digest words compared",
			messages_sent, words_sent, 4 * messages_sent);
		$display("including empty, short-word, padding-boundary and multi-block messages");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
